FILE: rtl/slot_allocator_reuse_delay_assert.svh
// Assertion macros for the slot allocator.
// Used by the top level only; depends on nothing else.
`ifndef SLOT_ALLOCATOR_REUSE_DELAY_ASSERT_SVH
`define SLOT_ALLOCATOR_REUSE_DELAY_ASSERT_SVH

`define SARD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot allocator: implication check failed");

`define SARD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot allocator: next-cycle check failed");

`endif

FILE: rtl/sard_pkg.sv
// Shared constants and codes for the slot allocator.
// Used by the channel interfaces and the top level; depends on nothing.
package sard_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int TICK_BITS  = 32;
    localparam int SLOT_BITS  = $clog2(SLOT_COUNT);

    localparam int ACTION_W   = 2;
    localparam int INDEX_W    = 10;
    localparam int STATUS_W   = 2;
    localparam int GRANT_W    = 10;
    localparam int SPAN_W     = 11;
    localparam int RS_W       = 10;
    localparam int DELAY_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam int PTR_W      = ((SLOT_BITS > RS_W) ? SLOT_BITS : RS_W) + 1;

    localparam logic [RS_W-1:0]    RS_RESET    = RS_W'(9);
    localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(50);

    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_REFUSED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 1'd1;

    typedef logic signed [PTR_W-1:0] ptr_t;

endpackage

FILE: rtl/sard_if.sv
// Valid/ready channel interfaces for the slot allocator.
// Depends on sard_pkg for field widths.
interface sard_req_if
    import sard_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  slot_index;

    modport source (output valid, action, slot_index, input ready);
    modport sink (input valid, action, slot_index, output ready);
endinterface

interface sard_rsp_if
    import sard_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [GRANT_W-1:0]  granted_slot;
    logic [SPAN_W-1:0]   slots_in_span;

    modport source (output valid, status, granted_slot, slots_in_span, input ready);
    modport sink (input valid, status, granted_slot, slots_in_span, output ready);
endinterface

interface sard_cfg_if
    import sard_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/sard_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module sard_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/slot_allocator_reuse_delay.sv
// Slot allocator with a high-water mark and a reuse quarantine.
// The request channel takes items of action and slot_index; each item gives one
// response item of status, granted_slot and slots_in_span. The cfg channel
// writes reserved_slots (index 0) and reuse_delay (index 1) and is always ready.
// After reset the block clears its in-use and free-time memories, one slot a
// cycle, all SLOT_COUNT (1024) slots, with request.ready low.
// A tick, a refused free or an unknown action goes straight from idle to done.
// Allocate and free walk slots one at a time through a single read port of the
// slot memories; each slot visited passes through a read state and then a check
// state. An allocate that falls back to the high mark passes through a grow
// state.
// The result sits in an output register; a new item is accepted while it waits.
// If the receiver stalls, the next result holds inside until the register is
// taken, and no further item is accepted meanwhile.
`include "slot_allocator_reuse_delay_assert.svh"

module slot_allocator_reuse_delay
    import sard_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sard_req_if.sink   request,
    sard_rsp_if.source response,
    sard_cfg_if.sink   cfg
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_CHK   = 3'd3;
    localparam logic [2:0] ST_GROW  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [SLOT_BITS-1:0] clr_reg, clr_next;
    logic [ACTION_W-1:0]  act_reg, act_next;
    ptr_t                 p_reg, p_next;
    ptr_t                 scan_reg, scan_next;
    ptr_t                 hm_reg, hm_next;
    logic [TICK_BITS-1:0] tick_reg, tick_next;
    logic [RS_W-1:0]      rs_reg;
    logic [DELAY_W-1:0]   delay_reg;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [GRANT_W-1:0]   res_grant_reg, res_grant_next;
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [GRANT_W-1:0]   out_grant_reg;
    logic [SPAN_W-1:0]    out_span_reg;

    logic                 use_we, tick_we;
    logic [SLOT_BITS-1:0] waddr;
    logic                 use_wdata;
    logic [TICK_BITS-1:0] tick_wdata;
    logic                 use_rd;
    logic [TICK_BITS-1:0] tick_rd;

    ptr_t                 rs_ext, p_dec, hm_dec;
    logic [TICK_BITS-1:0] age;
    logic                 slot_ok;
    logic                 load_out;

    sard_ram #(.WIDTH(1), .DEPTH(SLOT_COUNT)) u_use_ram (
        .clk   (clk),
        .we    (use_we),
        .waddr (waddr),
        .wdata (use_wdata),
        .raddr (p_reg[SLOT_BITS-1:0]),
        .rdata (use_rd)
    );

    sard_ram #(.WIDTH(TICK_BITS), .DEPTH(SLOT_COUNT)) u_tick_ram (
        .clk   (clk),
        .we    (tick_we),
        .waddr (waddr),
        .wdata (tick_wdata),
        .raddr (p_reg[SLOT_BITS-1:0]),
        .rdata (tick_rd)
    );

    assign rs_ext  = $signed(PTR_W'(rs_reg));
    assign p_dec   = p_reg - ptr_t'(1);
    assign hm_dec  = hm_reg - ptr_t'(1);
    assign age     = tick_reg - tick_rd;
    assign slot_ok = !use_rd && ((tick_rd == '0) || (age > TICK_BITS'(delay_reg)));

    assign request.ready = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign load_out      = (state_reg == ST_DONE) && (!out_valid_reg || response.ready);

    assign response.valid         = out_valid_reg;
    assign response.status        = out_status_reg;
    assign response.granted_slot  = out_grant_reg;
    assign response.slots_in_span = out_span_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        act_next        = act_reg;
        p_next          = p_reg;
        scan_next       = scan_reg;
        hm_next         = hm_reg;
        tick_next       = tick_reg;
        res_status_next = res_status_reg;
        res_grant_next  = res_grant_reg;
        use_we          = 1'b0;
        tick_we         = 1'b0;
        waddr           = p_reg[SLOT_BITS-1:0];
        use_wdata       = 1'b0;
        tick_wdata      = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                use_we   = 1'b1;
                tick_we  = 1'b1;
                waddr    = clr_reg;
                clr_next = clr_reg + SLOT_BITS'(1);
                if (clr_reg == SLOT_BITS'(SLOT_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    act_next        = request.action;
                    res_status_next = STAT_OK;
                    res_grant_next  = '0;
                    state_next      = ST_DONE;
                    case (request.action)
                        ACT_TICK:
                        begin
                            tick_next = tick_reg + TICK_BITS'(1);
                        end
                        ACT_ALLOC:
                        begin
                            p_next = scan_reg;
                            if (scan_reg >= rs_ext)
                            begin
                                state_next = ST_RD;
                            end
                            else
                            begin
                                state_next = ST_GROW;
                            end
                        end
                        ACT_FREE:
                        begin
                            if (request.slot_index < rs_reg)
                            begin
                                res_status_next = STAT_REFUSED;
                            end
                            else if (32'(request.slot_index) < SLOT_COUNT)
                            begin
                                use_we     = 1'b1;
                                tick_we    = 1'b1;
                                waddr      = SLOT_BITS'(request.slot_index);
                                tick_wdata = tick_reg;
                                p_next     = hm_dec;
                                if (hm_dec >= rs_ext)
                                begin
                                    state_next = ST_RD;
                                end
                                else
                                begin
                                    scan_next = hm_dec;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (act_reg == ACT_ALLOC)
                begin
                    if (slot_ok)
                    begin
                        use_we         = 1'b1;
                        use_wdata      = 1'b1;
                        scan_next      = p_reg;
                        res_grant_next = GRANT_W'(p_reg);
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        p_next = p_dec;
                        if (p_dec >= rs_ext)
                        begin
                            state_next = ST_RD;
                        end
                        else
                        begin
                            state_next = ST_GROW;
                        end
                    end
                end
                else
                begin
                    if (!use_rd)
                    begin
                        p_next  = p_dec;
                        hm_next = p_reg;
                        if (p_dec >= rs_ext)
                        begin
                            state_next = ST_RD;
                        end
                        else
                        begin
                            scan_next  = p_dec;
                            state_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        scan_next  = p_reg;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_GROW:
            begin
                state_next = ST_DONE;
                if (hm_reg >= $signed(PTR_W'(SLOT_COUNT - 1)))
                begin
                    res_status_next = STAT_FULL;
                end
                else
                begin
                    use_we         = 1'b1;
                    use_wdata      = 1'b1;
                    waddr          = hm_reg[SLOT_BITS-1:0];
                    scan_next      = hm_reg;
                    res_grant_next = GRANT_W'(hm_reg);
                    hm_next        = hm_reg + ptr_t'(1);
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            scan_reg      <= $signed(PTR_W'(RS_RESET)) - ptr_t'(1);
            hm_reg        <= $signed(PTR_W'(RS_RESET));
            tick_reg      <= '0;
            rs_reg        <= RS_RESET;
            delay_reg     <= DELAY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            scan_reg  <= scan_next;
            hm_reg    <= hm_next;
            tick_reg  <= tick_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_RESERVED: rs_reg    <= cfg.data[RS_W-1:0];
                    CFG_DELAY:    delay_reg <= cfg.data[DELAY_W-1:0];
                    default:      rs_reg    <= rs_reg;
                endcase
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        p_reg          <= p_next;
        res_status_reg <= res_status_next;
        res_grant_reg  <= res_grant_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_grant_reg  <= res_grant_reg;
            out_span_reg   <= SPAN_W'(hm_reg);
        end
    end

    `SARD_ASSERT_IMPL(a_scan_below_mark, clk, rst_n, state_reg == ST_IDLE, scan_reg < hm_reg)
    `SARD_ASSERT_NEXT(a_read_then_check, clk, rst_n, state_reg == ST_RD, state_reg == ST_CHK)
    `SARD_ASSERT_IMPL(a_full_only_at_top, clk, rst_n,
        response.valid && (response.status == STAT_FULL),
        response.slots_in_span == SPAN_W'(SLOT_COUNT - 1))

endmodule

FILE: bench/slot_allocator_reuse_delay_tb.sv
// Self-checking testbench for the slot allocator with reuse quarantine.
// Drives request and register channels, predicts each response item and compares it.
// Depends on sard_pkg, the channel interfaces in sard_if.sv and the top level.
`timescale 1ns / 100ps

module slot_allocator_reuse_delay_tb;
    import sard_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNDEFINED = 2'd3;
    localparam int WATCHDOG_LIMIT = 16000;
    localparam int PRINT_CAP = 50;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [GRANT_W-1:0]  granted_slot;
        logic [SPAN_W-1:0]   slots_in_span;
    } slot_result_t;

    logic clk;
    logic rst_n;

    sard_req_if request_ch();
    sard_rsp_if response_ch();
    sard_cfg_if cfg_ch();

    slot_allocator_reuse_delay dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (response_ch),
        .cfg      (cfg_ch)
    );

    // Shadow copy of the slot table and its registers.
    bit                  slot_busy [SLOT_COUNT];
    bit [TICK_BITS-1:0]  slot_freed_tick [SLOT_COUNT];
    bit [TICK_BITS-1:0]  frame_tick = '0;
    int                  scan_ptr = int'(RS_RESET) - 1;
    int                  span_mark = int'(RS_RESET);
    int                  rs_reg = int'(RS_RESET);
    logic [DELAY_W-1:0]  delay_reg = DELAY_RESET;

    slot_result_t awaited_results[$];
    int mismatch_count = 0;
    int stalled_cycles = 0;
    bit no_idle = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic slot_result_t predict_table_op(input logic [ACTION_W-1:0] act,
                                                      input logic [INDEX_W-1:0] idx);
        slot_result_t r;
        int p;
        bit found;
        bit [TICK_BITS-1:0] age;
        r.status = STAT_OK;
        r.granted_slot = '0;
        case (act)
            ACT_TICK:
            begin
                frame_tick = frame_tick + TICK_BITS'(1);
            end
            ACT_ALLOC:
            begin
                p = scan_ptr;
                found = 1'b0;
                if (p >= SLOT_COUNT)
                    p = SLOT_COUNT - 1;
                while (!found && p >= rs_reg && p >= 0)
                begin
                    age = frame_tick - slot_freed_tick[p];
                    if (!slot_busy[p] && (slot_freed_tick[p] == 0 || age > 32'(delay_reg)))
                        found = 1'b1;
                    else
                        p--;
                end
                if (found)
                begin
                    slot_busy[p] = 1'b1;
                    scan_ptr = p;
                    r.granted_slot = GRANT_W'(p);
                end
                else if (span_mark + 1 >= SLOT_COUNT || span_mark < 0)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    slot_busy[span_mark] = 1'b1;
                    scan_ptr = span_mark;
                    r.granted_slot = GRANT_W'(span_mark);
                    span_mark++;
                end
            end
            ACT_FREE:
            begin
                if (int'(idx) < rs_reg)
                begin
                    r.status = STAT_REFUSED;
                end
                else
                begin
                    slot_busy[idx] = 1'b0;
                    slot_freed_tick[idx] = frame_tick;
                    p = span_mark - 1;
                    while (p >= rs_reg && p >= 0 && p < SLOT_COUNT && !slot_busy[p])
                    begin
                        p--;
                        span_mark--;
                    end
                    scan_ptr = p;
                end
            end
            default:
            begin
            end
        endcase
        r.slots_in_span = SPAN_W'(span_mark);
        return r;
    endfunction

    function automatic int draw_pause();
        return no_idle ? 0 : $urandom_range(0, 7);
    endfunction

    task automatic flag_mismatch(input string field, input int seq, input int got,
                                 input int want);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch on result %0d, %s: got %0d, expected %0d",
                     seq, field, got, want);
        mismatch_count++;
    endtask

    task automatic issue_request(input logic [ACTION_W-1:0] act,
                                 input logic [INDEX_W-1:0] idx);
        int gap;
        gap = draw_pause();
        if (gap > 0)
        begin
            request_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_ch.valid <= 1'b1;
        request_ch.action <= act;
        request_ch.slot_index <= idx;
        @(posedge clk);
        while (!request_ch.ready)
            @(posedge clk);
        awaited_results.push_back(predict_table_op(act, idx));
    endtask

    task automatic wait_drained();
        request_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] which,
                                 input logic [CFG_DATA_W-1:0] value);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= which;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (which == CFG_RESERVED)
            rs_reg = int'(value);
        else
            delay_reg = value[DELAY_W-1:0];
    endtask

    // Frees mostly target the live span so that in-use and quarantined slots both come up.
    task automatic random_table_op();
        int roll;
        int hi;
        roll = $urandom_range(0, 99);
        hi = (span_mark + 1 > SLOT_COUNT - 1) ? SLOT_COUNT - 1 : span_mark + 1;
        if (hi < rs_reg)
            hi = rs_reg;
        if (roll < 40)
            issue_request(ACT_ALLOC, INDEX_W'($urandom_range(0, SLOT_COUNT - 1)));
        else if (roll < 70)
            issue_request(ACT_FREE, INDEX_W'($urandom_range(rs_reg, hi)));
        else if (roll < 90)
            issue_request(ACT_TICK, INDEX_W'($urandom_range(0, SLOT_COUNT - 1)));
        else if (roll < 95)
            issue_request(ACT_FREE, INDEX_W'($urandom_range(0, SLOT_COUNT - 1)));
        else
            issue_request(ACT_UNDEFINED, INDEX_W'($urandom_range(0, SLOT_COUNT - 1)));
    endtask

    task automatic test_directed_ops();
        issue_request(ACT_ALLOC, 10'h000);
        issue_request(ACT_ALLOC, 10'h3FF);
        issue_request(ACT_FREE, 10'd9);
        issue_request(ACT_ALLOC, 10'h000);
        issue_request(ACT_FREE, 10'd0);
        issue_request(ACT_FREE, 10'd8);
        issue_request(ACT_TICK, 10'h3FF);
        issue_request(ACT_TICK, 10'h155);
        issue_request(ACT_FREE, 10'd10);
        issue_request(ACT_ALLOC, 10'h2AA);
        issue_request(ACT_UNDEFINED, 10'h3FF);
        issue_request(ACT_FREE, 10'h3FF);
        issue_request(ACT_FREE, 10'd9);
        issue_request(ACT_FREE, 10'd9);
        issue_request(ACT_ALLOC, 10'h155);
        issue_request(ACT_ALLOC, 10'h000);
        issue_request(ACT_ALLOC, 10'h3FF);
        issue_request(ACT_UNDEFINED, 10'h000);
    endtask

    task automatic test_reuse_quarantine();
        write_setting(CFG_DELAY, CFG_DATA_W'(2));
        repeat (30) random_table_op();
        no_idle = 1'b1;
        repeat (20) random_table_op();
        no_idle = 1'b0;
        // Hold the sender until every outstanding item has come back.
        wait_drained();
        repeat (15) random_table_op();
        write_setting(CFG_DELAY, CFG_DATA_W'(0));
        repeat (20) random_table_op();
        write_setting(CFG_DELAY, CFG_DATA_W'(255));
        repeat (15) random_table_op();
    endtask

    // With every low slot reserved the scan is empty; allocates grow the mark until full.
    task automatic test_fill_to_full();
        write_setting(CFG_RESERVED, CFG_DATA_W'(SLOT_COUNT - 1));
        write_setting(CFG_DELAY, CFG_DATA_W'(1));
        while (span_mark < SLOT_COUNT - 1)
        begin
            no_idle = (span_mark % 256) < 64;
            if ($urandom_range(0, 15) == 0)
                random_table_op();
            else
                issue_request(ACT_ALLOC, INDEX_W'($urandom_range(0, SLOT_COUNT - 1)));
        end
        no_idle = 1'b0;
        repeat (6) issue_request(ACT_ALLOC, INDEX_W'($urandom_range(0, SLOT_COUNT - 1)));
    endtask

    task automatic test_high_region();
        write_setting(CFG_RESERVED, CFG_DATA_W'($urandom_range(1000, 1012)));
        write_setting(CFG_DELAY, CFG_DATA_W'($urandom_range(0, 7)));
        repeat (40) random_table_op();
    endtask

    task automatic test_low_reserved();
        write_setting(CFG_RESERVED, CFG_DATA_W'(1));
        repeat (15) random_table_op();
    endtask

    initial
    begin : result_checker
        int stall;
        int seq;
        slot_result_t want;
        seq = 0;
        response_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_pause();
            if (stall > 0)
            begin
                response_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            response_ch.ready <= 1'b1;
            @(posedge clk);
            while (!response_ch.valid)
                @(posedge clk);
            if (awaited_results.size() == 0)
            begin
                flag_mismatch("result with nothing awaited", seq,
                              int'(response_ch.status), -1);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (response_ch.status !== want.status)
                    flag_mismatch("status", seq, int'(response_ch.status),
                                  int'(want.status));
                if (response_ch.granted_slot !== want.granted_slot)
                    flag_mismatch("granted_slot", seq, int'(response_ch.granted_slot),
                                  int'(want.granted_slot));
                if (response_ch.slots_in_span !== want.slots_in_span)
                    flag_mismatch("slots_in_span", seq, int'(response_ch.slots_in_span),
                                  int'(want.slots_in_span));
            end
            seq++;
        end
    end

    always @(posedge clk)
    begin
        if ((request_ch.valid && request_ch.ready) ||
            (response_ch.valid && response_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            stalled_cycles <= 0;
        end
        else if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("slot_allocator_reuse_delay_tb NOT OK");
            $finish;
        end
        else
        begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        request_ch.valid = 1'b0;
        request_ch.action = ACT_TICK;
        request_ch.slot_index = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_RESERVED;
        cfg_ch.data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_ops();
        test_reuse_quarantine();
        test_fill_to_full();
        test_high_region();
        test_low_reserved();

        wait_drained();
        repeat (64) @(posedge clk);
        if (mismatch_count == 0)
            $display("slot_allocator_reuse_delay_tb OK");
        else
            $display("slot_allocator_reuse_delay_tb NOT OK");
        $finish;
    end

endmodule
